// File: src/bmsi_pkg.sv
// Shared types and constants for the bank mapper with scanline interrupt.
`default_nettype none
package bmsi_pkg;

	// Item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_PRG   = 2'd2;
	localparam logic [1:0] MODE_CHR   = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN    = 1'b1;
	localparam int CFG_DATA_W = 7;

	localparam logic [6:0] PRG_COUNT_RESET = 7'd64;
	localparam logic [6:0] PRG_COUNT_MIN   = 7'd2;
	localparam logic [6:0] PRG_COUNT_MAX   = 7'd64;

	// Address windows, selected by address bits 15..13
	localparam logic [2:0] WIN_RAM      = 3'b011;
	localparam logic [2:0] WIN_BANK     = 3'b100;
	localparam logic [2:0] WIN_MIRROR   = 3'b101;
	localparam logic [2:0] WIN_IRQ_CNT  = 3'b110;
	localparam logic [2:0] WIN_IRQ_EN   = 3'b111;

	// Bank register file
	localparam int BANK_REGS  = 8;
	localparam int BANK_AW    = $clog2(BANK_REGS);
	localparam logic [BANK_AW-1:0] PRG_REG_A = 3'd6;
	localparam logic [BANK_AW-1:0] PRG_REG_B = 3'd7;
	localparam logic [BANK_AW-1:0] CHR_REG_BASE = 3'd2;

	localparam int COUNT_W = 10;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  value;
	} in_item_t;

	typedef struct packed {
		logic        irq_pulse;
		logic        write_allowed;
		logic        mirroring;
		logic [5:0]  prg_bank;
		logic [7:0]  chr_bank;
	} out_item_t;

	typedef struct packed {
		logic               wr_en;
		logic [BANK_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
		logic               rd_en;
		logic [BANK_AW-1:0] rd_addr;
	} ram_req_t;

	// Per-item control carried to the stage where bank data returns
	typedef struct packed {
		logic [1:0] mode;
		logic       irq_pulse;
		logic       write_allowed;
		logic       mirroring;
		logic       prg_zero;    // lookup below the program space
		logic       prg_fixed;   // window uses a fixed bank
		logic [5:0] prg_fixed_bank;
		logic       chr_pair;    // 2 KB register, low bit from address
		logic       chr_low_bit;
	} stage_t;

endpackage
`default_nettype wire

// File: src/bmsi_bank_ram.sv
// Bank register memory: one write port, one registered read port, reset via valid bits.
`default_nettype none
module bmsi_bank_ram (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bmsi_pkg::ram_req_t  req,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [bmsi_pkg::BANK_REGS];
	logic [bmsi_pkg::BANK_REGS-1:0] valid_q;
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : 8'd0;
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: src/bmsi_decode.sv
// Register decode, scanline counter and address translation ahead of the bank read.
`default_nettype none
module bmsi_decode (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire bmsi_pkg::in_item_t                item,
	input  wire logic                              cfg_we,
	input  wire logic [bmsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmsi_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bmsi_pkg::ram_req_t                     ram_req,
	output bmsi_pkg::stage_t                       stage
);

	logic [6:0] prg_count_q;
	logic       four_screen_q;
	logic [7:0] bank_select_q;
	logic       mirror_q;
	logic       protect_q;
	logic [7:0] latch_q;
	logic [bmsi_pkg::COUNT_W-1:0] count_q;
	logic       irq_on_q;

	logic [2:0] win3;
	logic       odd;
	logic       is_write;
	logic       is_tick;
	logic [bmsi_pkg::COUNT_W-1:0] count_dec;
	logic       count_zero;
	logic       count_load;
	logic       mirror_next;
	logic [6:0] n_clamped;
	logic [1:0] prg_win;
	logic [12:0] chr_addr;
	logic [2:0] kb;

	assign win3     = item.address[15:13];
	assign odd      = item.address[0];
	assign is_write = (item.mode == bmsi_pkg::MODE_WRITE);
	assign is_tick  = (item.mode == bmsi_pkg::MODE_TICK);

	assign count_dec  = count_q - {{(bmsi_pkg::COUNT_W-1){1'b0}}, 1'b1};
	assign count_zero = (count_dec == '0);
	assign count_load = count_zero || count_dec[bmsi_pkg::COUNT_W-1];

	always_comb begin
		mirror_next = mirror_q;
		if (is_write && win3 == bmsi_pkg::WIN_MIRROR && !odd && !four_screen_q) begin
			mirror_next = item.value[0];
		end
	end

	always_comb begin
		if (prg_count_q < bmsi_pkg::PRG_COUNT_MIN) begin
			n_clamped = bmsi_pkg::PRG_COUNT_MIN;
		end else if (prg_count_q > bmsi_pkg::PRG_COUNT_MAX) begin
			n_clamped = bmsi_pkg::PRG_COUNT_MAX;
		end else begin
			n_clamped = prg_count_q;
		end
	end

	// Swap the first and third program windows when bit 6 of bank select is set
	assign prg_win = {item.address[14] ^ (bank_select_q[6] & ~item.address[13]),
		item.address[13]};

	assign chr_addr = {item.address[12] ^ bank_select_q[7], item.address[11:0]};
	assign kb       = chr_addr[12:10];

	always_comb begin
		ram_req.wr_en   = accept && is_write && win3 == bmsi_pkg::WIN_BANK && odd;
		ram_req.wr_addr = bank_select_q[bmsi_pkg::BANK_AW-1:0];
		ram_req.wr_data = item.value;
		ram_req.rd_en   = accept;
		if (item.mode == bmsi_pkg::MODE_PRG) begin
			ram_req.rd_addr = prg_win[0] ? bmsi_pkg::PRG_REG_B : bmsi_pkg::PRG_REG_A;
		end else if (!kb[2]) begin
			ram_req.rd_addr = {2'b00, kb[1]};
		end else begin
			ram_req.rd_addr = bmsi_pkg::CHR_REG_BASE + {1'b0, kb[1:0]};
		end
	end

	always_comb begin
		stage.mode          = item.mode;
		stage.irq_pulse     = is_tick && count_zero && irq_on_q;
		stage.write_allowed = !(is_write && protect_q && win3 == bmsi_pkg::WIN_RAM);
		stage.mirroring     = mirror_next;
		stage.prg_zero      = !item.address[15];
		stage.prg_fixed     = prg_win[1];
		stage.prg_fixed_bank = prg_win[0] ? 6'(n_clamped - 7'd1) : 6'(n_clamped - 7'd2);
		stage.chr_pair      = !kb[2];
		stage.chr_low_bit   = kb[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= bmsi_pkg::PRG_COUNT_RESET;
			four_screen_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bmsi_pkg::CFG_PRG_BANK_COUNT: prg_count_q   <= cfg_data;
				bmsi_pkg::CFG_FOUR_SCREEN:    four_screen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			mirror_q      <= 1'b0;
			protect_q     <= 1'b0;
			latch_q       <= '0;
			count_q       <= '0;
			irq_on_q      <= 1'b0;
		end else if (accept) begin
			mirror_q <= mirror_next;
			if (is_tick) begin
				count_q <= count_load ? {2'b00, latch_q} : count_dec;
			end else if (is_write) begin
				case (win3)
					bmsi_pkg::WIN_BANK: begin
						if (!odd) bank_select_q <= item.value;
					end
					bmsi_pkg::WIN_MIRROR: begin
						if (odd) protect_q <= item.value[6];
					end
					bmsi_pkg::WIN_IRQ_CNT: begin
						if (odd) count_q <= '1;
						else latch_q <= item.value;
					end
					bmsi_pkg::WIN_IRQ_EN: begin
						irq_on_q <= odd;
					end
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// File: src/bank_mapper_with_scanline_irq.sv
// Top level of the bank mapper with scanline interrupt counter.
// Every transaction (cpu write, scanline tick, program lookup or pattern lookup)
// yields one result. Register, counter and mirroring updates take effect at the
// edge the transaction is accepted; the eight bank registers live in a small
// synchronous memory read at that same edge, so the result is formed from the
// registered bank read and stage_s1 and is then held in the output register,
// where a stalled output side can keep it waiting. One transaction is accepted
// per cycle while the output side keeps taking results. Configuration writes
// land at the edge cfg_we is high and should be made while no transaction is in
// flight.
`default_nettype none
module bank_mapper_with_scanline_irq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire bmsi_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output bmsi_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_we,
	input  wire logic [bmsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmsi_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                 accept;
	bmsi_pkg::ram_req_t   ram_req;
	bmsi_pkg::stage_t     stage_next;
	bmsi_pkg::stage_t     stage_s1;
	logic                 valid_s1;
	logic [7:0]           bank_data;
	logic                 advance;
	bmsi_pkg::out_item_t  result;
	bmsi_pkg::out_item_t  out_q;
	logic                 out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	bmsi_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_req   (ram_req),
		.stage     (stage_next)
	);

	bmsi_bank_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (bank_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_next;
		end
	end

	// Merge bank data with the decoded control
	always_comb begin
		result.irq_pulse     = stage_s1.irq_pulse;
		result.write_allowed = stage_s1.write_allowed;
		result.mirroring     = stage_s1.mirroring;
		result.prg_bank      = 6'd0;
		result.chr_bank      = 8'd0;
		case (stage_s1.mode)
			bmsi_pkg::MODE_PRG: begin
				if (!stage_s1.prg_zero) begin
					result.prg_bank = stage_s1.prg_fixed ? stage_s1.prg_fixed_bank
						: bank_data[5:0];
				end
			end
			bmsi_pkg::MODE_CHR: begin
				result.chr_bank = stage_s1.chr_pair ? {bank_data[7:1], stage_s1.chr_low_bit}
					: bank_data;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled while the pipeline has room");

	a_pulse_only_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.irq_pulse) |->
		(out_q.prg_bank == 6'd0 && out_q.chr_bank == 8'd0 && out_q.write_allowed))
		else $error("irq pulse on a non-tick result");

	a_output_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a staged transaction");
`endif

endmodule
`default_nettype wire
